### design/qkt_pkg.sv
// ============================================================================
// qkt_pkg
// Shared types, token codes, character constants and the keyword table of
// the query keyword tokenizer.
// ============================================================================
`default_nettype none

package qkt_pkg;

  // Word buffer geometry.
  localparam int MAX_WORD_LEN = 11;
  localparam int LEN_W        = $clog2(MAX_WORD_LEN + 1);
  localparam int IDX_W        = $clog2(MAX_WORD_LEN);

  // Keyword table: each entry is padded with trailing spaces to KW_CHARS bytes.
  localparam int NUM_KEYWORDS = 14;
  localparam int KW_CHARS     = 11;

  localparam logic [KW_CHARS*8-1:0] KW_TEXT [NUM_KEYWORDS] = '{
    "select     ",
    "where      ",
    "files      ",
    "directories",
    "all        ",
    "recursive  ",
    "move       ",
    "copy       ",
    "delete     ",
    "display    ",
    "extension  ",
    "size       ",
    "and        ",
    "or         "
  };

  localparam int KW_LEN [NUM_KEYWORDS] = '{6, 5, 5, 11, 3, 9, 4, 4, 6, 7, 9, 4, 3, 2};

  // Token codes.
  typedef logic [4:0] token_code_t;

  localparam token_code_t CODE_NONE    = 5'd0;
  localparam token_code_t CODE_STRING  = 5'd14;
  localparam token_code_t CODE_EQ      = 5'd15;
  localparam token_code_t CODE_SEMI    = 5'd16;
  localparam token_code_t CODE_LPAREN  = 5'd17;
  localparam token_code_t CODE_RPAREN  = 5'd18;
  localparam token_code_t CODE_COMMA   = 5'd19;
  localparam token_code_t CODE_NUMBER  = 5'd20;
  localparam token_code_t CODE_DONE    = 5'd21;
  localparam token_code_t CODE_INVALID = 5'd22;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Lexer modes.
  typedef enum logic [4:0] {
    MODE_IDLE   = 5'b00001,
    MODE_STRING = 5'b00010,
    MODE_NUMBER = 5'b00100,
    MODE_WORD   = 5'b01000,
    MODE_DEAD   = 5'b10000
  } lex_mode_t;

  // One result item.
  typedef struct packed {
    token_code_t token_code;
    logic        token_done;
    logic [7:0]  lexeme_char;
    logic        char_valid;
    logic        last_result;
  } result_t;

  // Results of one input item, handed from the lexer to the output queue.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // Builds a result with the last flag clear.
  function automatic result_t mk_res(token_code_t code, logic done, logic [7:0] ch,
                                     logic cv);
    result_t r;
    r.token_code  = code;
    r.token_done  = done;
    r.lexeme_char = ch;
    r.char_valid  = cv;
    r.last_result = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

### design/qkt_in_if.sv
// ============================================================================
// qkt_in_if
// Source character channel: valid/ready handshake with a byte and an
// end-of-input flag.
// ============================================================================
`default_nettype none

interface qkt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_input;

  modport source (output valid, output in_char, output end_of_input, input ready);
  modport sink   (input valid, input in_char, input end_of_input, output ready);
endinterface

`default_nettype wire

### design/qkt_out_if.sv
// ============================================================================
// qkt_out_if
// Token result channel: valid/ready handshake with one result item.
// ============================================================================
`default_nettype none

interface qkt_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] token_code;
  logic       token_done;
  logic [7:0] lexeme_char;
  logic       char_valid;
  logic       last_result;

  modport source (output valid, output token_code, output token_done,
                  output lexeme_char, output char_valid, output last_result,
                  input ready);
  modport sink   (input valid, input token_code, input token_done,
                  input lexeme_char, input char_valid, input last_result,
                  output ready);
endinterface

`default_nettype wire

### design/qkt_lexer.sv
// ============================================================================
// qkt_lexer
// Input register, lexer state, word buffer and keyword match. Each item
// yields up to two results, pushed into the output queue in the same cycle.
// ============================================================================
`default_nettype none

module qkt_lexer (
  input  wire             clk,
  input  wire             rst,
  qkt_in_if.sink          item_in,
  input  wire             room,
  output qkt_pkg::push_t  push
);

  // Input register.
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_eoi;
  logic       adv;

  // Lexer state.
  qkt_pkg::lex_mode_t             mode;
  qkt_pkg::lex_mode_t             mode_next;
  logic [qkt_pkg::LEN_W-1:0]      len;
  logic [qkt_pkg::LEN_W-1:0]      len_next;
  logic [7:0]                     word_buf [qkt_pkg::MAX_WORD_LEN];
  logic                           wr_en;
  logic [qkt_pkg::IDX_W-1:0]      wr_idx;

  // Character classes.
  logic is_space;
  logic is_letter;
  logic is_digit;

  // Outcome of handling the character as in idle.
  logic                ic_emit;
  qkt_pkg::result_t    ic_res;
  qkt_pkg::lex_mode_t  ic_mode;
  logic                ic_start;

  // Keyword match.
  logic                 kw_hit;
  logic                 kw_eq;
  qkt_pkg::token_code_t kw_code;

  // Results of this item.
  logic [1:0]       n_res;
  qkt_pkg::result_t r0;
  qkt_pkg::result_t r1;

  // The registered item moves on when the queue has room for two results.
  assign adv          = in_valid && room;
  assign item_in.ready = !in_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item_in.ready) begin
      in_valid <= item_in.valid;
    end
    if (item_in.ready && item_in.valid) begin
      in_char <= item_in.in_char;
      in_eoi  <= item_in.end_of_input;
    end
  end

  // Character classes of the registered byte.
  assign is_space  = (in_char == qkt_pkg::CH_SPACE) ||
                     ((in_char >= qkt_pkg::CH_TAB) && (in_char <= qkt_pkg::CH_CR));
  assign is_letter = ((in_char >= 8'h61) && (in_char <= 8'h7A)) ||
                     ((in_char >= 8'h41) && (in_char <= 8'h5A));
  assign is_digit  = (in_char >= 8'h30) && (in_char <= 8'h39);

  // Compare the buffered word against every keyword in parallel.
  always_comb begin
    kw_hit  = 1'b0;
    kw_code = qkt_pkg::CODE_NONE;
    kw_eq   = 1'b0;
    for (int k = 0; k < qkt_pkg::NUM_KEYWORDS; k++) begin
      kw_eq = (len == qkt_pkg::LEN_W'(qkt_pkg::KW_LEN[k]));
      for (int i = 0; i < qkt_pkg::KW_CHARS; i++) begin
        if ((i < qkt_pkg::KW_LEN[k]) &&
            (word_buf[i] != qkt_pkg::KW_TEXT[k][(qkt_pkg::KW_CHARS-1-i)*8 +: 8])) begin
          kw_eq = 1'b0;
        end
      end
      if (kw_eq) begin
        kw_hit  = 1'b1;
        kw_code = 5'(k);
      end
    end
  end

  // What a character does when no token is open.
  always_comb begin
    ic_emit  = 1'b0;
    ic_res   = '0;
    ic_mode  = qkt_pkg::MODE_IDLE;
    ic_start = 1'b0;
    if (!is_space) begin
      case (in_char)
        qkt_pkg::CH_QUOTE: begin
          ic_mode = qkt_pkg::MODE_STRING;
        end
        qkt_pkg::CH_EQ: begin
          ic_emit = 1'b1;
          ic_res  = qkt_pkg::mk_res(qkt_pkg::CODE_EQ, 1'b1, in_char, 1'b1);
        end
        qkt_pkg::CH_SEMI: begin
          ic_emit = 1'b1;
          ic_res  = qkt_pkg::mk_res(qkt_pkg::CODE_SEMI, 1'b1, in_char, 1'b1);
        end
        qkt_pkg::CH_LPAREN: begin
          ic_emit = 1'b1;
          ic_res  = qkt_pkg::mk_res(qkt_pkg::CODE_LPAREN, 1'b1, in_char, 1'b1);
        end
        qkt_pkg::CH_RPAREN: begin
          ic_emit = 1'b1;
          ic_res  = qkt_pkg::mk_res(qkt_pkg::CODE_RPAREN, 1'b1, in_char, 1'b1);
        end
        qkt_pkg::CH_COMMA: begin
          ic_emit = 1'b1;
          ic_res  = qkt_pkg::mk_res(qkt_pkg::CODE_COMMA, 1'b1, in_char, 1'b1);
        end
        default: begin
          ic_emit = 1'b1;
          if (is_letter) begin
            ic_mode  = qkt_pkg::MODE_WORD;
            ic_start = 1'b1;
            ic_res   = qkt_pkg::mk_res(qkt_pkg::CODE_NONE, 1'b0, in_char, 1'b1);
          end else if (is_digit) begin
            ic_mode = qkt_pkg::MODE_NUMBER;
            ic_res  = qkt_pkg::mk_res(qkt_pkg::CODE_NONE, 1'b0, in_char, 1'b1);
          end else begin
            ic_mode = qkt_pkg::MODE_DEAD;
            ic_res  = qkt_pkg::mk_res(qkt_pkg::CODE_INVALID, 1'b1, 8'h00, 1'b0);
          end
        end
      endcase
    end
  end

  // Main lexer step: results, next mode and word buffer write.
  always_comb begin
    n_res     = 2'd0;
    r0        = '0;
    r1        = '0;
    mode_next = mode;
    len_next  = len;
    wr_en     = 1'b0;
    wr_idx    = len[qkt_pkg::IDX_W-1:0];
    unique case (mode)
      qkt_pkg::MODE_IDLE: begin
        if (in_eoi) begin
          r0    = qkt_pkg::mk_res(qkt_pkg::CODE_DONE, 1'b1, 8'h00, 1'b0);
          n_res = 2'd1;
        end else begin
          r0        = ic_res;
          n_res     = {1'b0, ic_emit};
          mode_next = ic_mode;
          if (ic_start) begin
            wr_en    = 1'b1;
            wr_idx   = '0;
            len_next = qkt_pkg::LEN_W'(1);
          end
        end
      end
      qkt_pkg::MODE_STRING: begin
        if (in_eoi) begin
          r0        = qkt_pkg::mk_res(qkt_pkg::CODE_STRING, 1'b1, 8'h00, 1'b0);
          r1        = qkt_pkg::mk_res(qkt_pkg::CODE_DONE, 1'b1, 8'h00, 1'b0);
          n_res     = 2'd2;
          mode_next = qkt_pkg::MODE_IDLE;
        end else if (in_char == qkt_pkg::CH_QUOTE) begin
          r0        = qkt_pkg::mk_res(qkt_pkg::CODE_STRING, 1'b1, 8'h00, 1'b0);
          n_res     = 2'd1;
          mode_next = qkt_pkg::MODE_IDLE;
        end else if (!is_space) begin
          r0    = qkt_pkg::mk_res(qkt_pkg::CODE_NONE, 1'b0, in_char, 1'b1);
          n_res = 2'd1;
        end
      end
      qkt_pkg::MODE_NUMBER: begin
        if (in_eoi) begin
          r0        = qkt_pkg::mk_res(qkt_pkg::CODE_NUMBER, 1'b1, 8'h00, 1'b0);
          r1        = qkt_pkg::mk_res(qkt_pkg::CODE_DONE, 1'b1, 8'h00, 1'b0);
          n_res     = 2'd2;
          mode_next = qkt_pkg::MODE_IDLE;
        end else if (is_digit) begin
          r0    = qkt_pkg::mk_res(qkt_pkg::CODE_NONE, 1'b0, in_char, 1'b1);
          n_res = 2'd1;
        end else begin
          // Close the number, then treat the character as in idle.
          r0        = qkt_pkg::mk_res(qkt_pkg::CODE_NUMBER, 1'b1, 8'h00, 1'b0);
          r1        = ic_res;
          n_res     = ic_emit ? 2'd2 : 2'd1;
          mode_next = ic_mode;
          if (ic_start) begin
            wr_en    = 1'b1;
            wr_idx   = '0;
            len_next = qkt_pkg::LEN_W'(1);
          end
        end
      end
      qkt_pkg::MODE_WORD: begin
        if (in_eoi) begin
          if (kw_hit) begin
            r0        = qkt_pkg::mk_res(kw_code, 1'b1, 8'h00, 1'b0);
            r1        = qkt_pkg::mk_res(qkt_pkg::CODE_DONE, 1'b1, 8'h00, 1'b0);
            n_res     = 2'd2;
            mode_next = qkt_pkg::MODE_IDLE;
          end else begin
            r0        = qkt_pkg::mk_res(qkt_pkg::CODE_INVALID, 1'b1, 8'h00, 1'b0);
            n_res     = 2'd1;
            mode_next = qkt_pkg::MODE_DEAD;
          end
        end else if (is_letter) begin
          if (len >= qkt_pkg::LEN_W'(qkt_pkg::MAX_WORD_LEN)) begin
            // The word outgrows the buffer.
            r0        = qkt_pkg::mk_res(qkt_pkg::CODE_INVALID, 1'b1, 8'h00, 1'b0);
            n_res     = 2'd1;
            mode_next = qkt_pkg::MODE_DEAD;
          end else begin
            wr_en    = 1'b1;
            len_next = len + qkt_pkg::LEN_W'(1);
            r0       = qkt_pkg::mk_res(qkt_pkg::CODE_NONE, 1'b0, in_char, 1'b1);
            n_res    = 2'd1;
          end
        end else if (kw_hit) begin
          // Close the keyword, then treat the character as in idle.
          r0        = qkt_pkg::mk_res(kw_code, 1'b1, 8'h00, 1'b0);
          r1        = ic_res;
          n_res     = ic_emit ? 2'd2 : 2'd1;
          mode_next = ic_mode;
          if (ic_start) begin
            wr_en    = 1'b1;
            wr_idx   = '0;
            len_next = qkt_pkg::LEN_W'(1);
          end
        end else begin
          r0        = qkt_pkg::mk_res(qkt_pkg::CODE_INVALID, 1'b1, 8'h00, 1'b0);
          n_res     = 2'd1;
          mode_next = qkt_pkg::MODE_DEAD;
        end
      end
      qkt_pkg::MODE_DEAD: begin
        n_res = 2'd0;
      end
      default: begin
        mode_next = qkt_pkg::MODE_IDLE;
      end
    endcase
    if (n_res == 2'd1) begin
      r0.last_result = 1'b1;
    end
    if (n_res == 2'd2) begin
      r1.last_result = 1'b1;
    end
  end

  // State update when the item is handed on.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= qkt_pkg::MODE_IDLE;
      len  <= '0;
    end else if (adv) begin
      mode <= mode_next;
      len  <= len_next;
    end
  end

  // Word buffer: written one letter at a time, no reset.
  always_ff @(posedge clk) begin
    if (adv && wr_en) begin
      word_buf[wr_idx] <= in_char;
    end
  end

  assign push.count  = adv ? n_res : 2'd0;
  assign push.first  = r0;
  assign push.second = r1;

endmodule

`default_nettype wire

### design/qkt_out_queue.sv
// ============================================================================
// qkt_out_queue
// Four-entry queue: takes up to two results per cycle, delivers one on ready.
// ============================================================================
`default_nettype none

module qkt_out_queue (
  input  wire             clk,
  input  wire             rst,
  input  qkt_pkg::push_t  push,
  output logic            room,
  qkt_out_if.source       result_out
);

  qkt_pkg::result_t entry [4];
  logic [1:0]       head;
  logic [1:0]       tail;
  logic [2:0]       fill;
  logic             pop;
  qkt_pkg::result_t head_res;

  // Room for a full pair of results, judged on the registered fill only.
  assign room = (fill <= 3'd2);
  assign pop  = (fill != 3'd0) && result_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      head <= head + {1'b0, pop};
      tail <= tail + push.count;
      fill <= fill + {1'b0, push.count} - {2'b00, pop};
    end
  end

  // Entry storage, no reset.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entry[tail] <= push.first;
    end
    if (push.count == 2'd2) begin
      entry[tail + 2'd1] <= push.second;
    end
  end

  assign head_res               = entry[head];
  assign result_out.valid       = (fill != 3'd0);
  assign result_out.token_code  = head_res.token_code;
  assign result_out.token_done  = head_res.token_done;
  assign result_out.lexeme_char = head_res.lexeme_char;
  assign result_out.char_valid  = head_res.char_valid;
  assign result_out.last_result = head_res.last_result;

endmodule

`default_nettype wire

### design/query_keyword_tokenizer_unit.sv
// ============================================================================
// query_keyword_tokenizer_unit
// Tokenizer for a small query language: one character or end-of-input mark
// per item in, character echoes and token codes out.
// ============================================================================
//
//   Channel     Dir  Payload                                        Handshake
//   item_in     in   in_char[8], end_of_input                       valid/ready
//   result_out  out  token_code[5], token_done, lexeme_char[8],     valid/ready
//                    char_valid, last_result
//
// One item is accepted per cycle while the four-entry result queue holds at
// most two results; an item gives zero, one or two results, delivered one
// per cycle while result_out.ready is high, via input register and queue.
// Synchronous reset returns the lexer to idle and empties the queue.
// A stall on the result side fills the queue and then holds the input
// register, which in turn drops item_in.ready.
`default_nettype none

module query_keyword_tokenizer_unit (
  input  wire        clk,
  input  wire        rst,
  qkt_in_if.sink     item_in,
  qkt_out_if.source  result_out
);

  qkt_pkg::push_t push;
  logic           room;

  // Lexer with its input register.
  qkt_lexer u_lexer (
    .clk     (clk),
    .rst     (rst),
    .item_in (item_in),
    .room    (room),
    .push    (push)
  );

  // Result queue in front of the output channel.
  qkt_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .result_out (result_out)
  );

endmodule

`default_nettype wire
